[src/w3kf_pkg.sv]
// Shared types and constants for the 3x3 window kernel filter.
package w3kf_pkg;

    typedef logic [7:0] pix_t;

    // Full 3x3 neighborhood: [row][col], row 0 top, col 0 left.
    typedef logic [2:0][2:0][7:0] win_t;

    typedef enum logic [2:0] {
        KM_BOX           = 3'd0,
        KM_GAUSS         = 3'd1,
        KM_PREWITT_X     = 3'd2,
        KM_PREWITT_Y     = 3'd3,
        KM_SOBEL_X       = 3'd4,
        KM_SOBEL_Y       = 3'd5,
        KM_LAPLACE       = 3'd6,
        KM_LAPLACE_SHARP = 3'd7
    } kernel_mode_t;

    typedef enum logic [1:0] {
        REG_KERNEL_MODE  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_index_t;

    localparam int          CFG_DW         = 11;
    localparam logic [10:0] WIDTH_RESET    = 11'd640;
    localparam logic [10:0] HEIGHT_RESET   = 11'd480;
    localparam logic [10:0] DIM_MIN        = 11'd3;
    localparam logic [10:0] HEIGHT_MAX     = 11'd1024;

    // floor(s * 0.11111) for s <= 2295: (s * BOX_RECIP) >> BOX_SHIFT, exact.
    localparam logic [24:0] BOX_RECIP      = 25'd29825864;
    localparam int          BOX_SHIFT      = 28;
    // floor(v / 3) for v < 2045: (v * DIV3_RECIP) >> DIV3_SHIFT, exact.
    localparam logic [9:0]  DIV3_RECIP     = 10'd683;
    localparam int          DIV3_SHIFT     = 11;

endpackage

[src/w3kf_stream_if.sv]
// Valid/ready stream interfaces for the pixel input and the filtered output.
interface w3kf_pix_in_if;
    logic             valid;
    logic             ready;
    w3kf_pkg::pix_t   pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface w3kf_pix_out_if;
    logic             valid;
    logic             ready;
    w3kf_pkg::pix_t   pixel_out;
    logic [9:0]       centre_x;
    logic [9:0]       centre_y;

    modport source (output valid, output pixel_out, output centre_x, output centre_y,
                    input ready);
    modport sink   (input valid, input pixel_out, input centre_x, input centre_y,
                    output ready);
endinterface

[src/w3kf_line_buf.sv]
// Two line stores (upper and middle row) with registered read data.
module w3kf_line_buf #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output w3kf_pkg::pix_t           up_q,
    output w3kf_pkg::pix_t           mid_q,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  w3kf_pkg::pix_t           wr_up,
    input  w3kf_pkg::pix_t           wr_mid
);
    import w3kf_pkg::*;

    pix_t upper_mem [DEPTH];
    pix_t middle_mem [DEPTH];
    pix_t up_q_reg;
    pix_t mid_q_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            up_q_reg  <= upper_mem[rd_addr];
            mid_q_reg <= middle_mem[rd_addr];
        end
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_up;
            middle_mem[wr_addr] <= wr_mid;
        end
    end

    assign up_q  = up_q_reg;
    assign mid_q = mid_q_reg;

endmodule

[src/w3kf_kernel.sv]
// Combinational 3x3 kernel evaluation for the eight filter modes.
module w3kf_kernel (
    input  w3kf_pkg::win_t         win,
    input  w3kf_pkg::kernel_mode_t mode,
    output w3kf_pkg::pix_t         result
);
    import w3kf_pkg::*;

    function automatic logic [11:0] abs13(input logic signed [12:0] v);
        logic signed [12:0] n;
        begin
            n = -v;
            abs13 = v[12] ? n[11:0] : v[11:0];
        end
    endfunction

    function automatic logic signed [12:0] s13(input logic [11:0] v);
        s13 = $signed({1'b0, v});
    endfunction

    logic [11:0] sum_t, sum_b, sum_l, sum_r, sum_all, others;
    logic [11:0] corners, edges, ctr, gauss_sum;
    logic [11:0] ctr8, ctr9;
    logic signed [12:0] d_px, d_py, d_sx, d_sy, d_lap, d_shp;
    logic [11:0] a_px, a_py, a_sx, a_sy, a_lap;
    logic [21:0] q_px, q_py;
    logic [36:0] box_prod;

    always_comb
    begin
        ctr     = {4'd0, win[1][1]};
        sum_t   = {4'd0, win[0][0]} + {4'd0, win[0][1]} + {4'd0, win[0][2]};
        sum_b   = {4'd0, win[2][0]} + {4'd0, win[2][1]} + {4'd0, win[2][2]};
        sum_l   = {4'd0, win[0][0]} + {4'd0, win[1][0]} + {4'd0, win[2][0]};
        sum_r   = {4'd0, win[0][2]} + {4'd0, win[1][2]} + {4'd0, win[2][2]};
        sum_all = sum_t + sum_b + {4'd0, win[1][0]} + ctr + {4'd0, win[1][2]};
        others  = sum_all - ctr;
        corners = {4'd0, win[0][0]} + {4'd0, win[0][2]} + {4'd0, win[2][0]}
                + {4'd0, win[2][2]};
        edges   = {4'd0, win[0][1]} + {4'd0, win[1][0]} + {4'd0, win[1][2]}
                + {4'd0, win[2][1]};
        gauss_sum = corners + {edges[10:0], 1'b0} + {ctr[9:0], 2'b00};
        ctr8    = {ctr[8:0], 3'b000};
        ctr9    = ctr8 + ctr;

        d_px  = s13(sum_r) - s13(sum_l);
        d_py  = s13(sum_b) - s13(sum_t);
        d_sx  = s13(sum_r + {4'd0, win[1][2]}) - s13(sum_l + {4'd0, win[1][0]});
        d_sy  = s13(sum_b + {4'd0, win[2][1]}) - s13(sum_t + {4'd0, win[0][1]});
        d_lap = s13(ctr8) - s13(others);
        d_shp = s13(ctr9) - s13(others);

        a_px  = abs13(d_px);
        a_py  = abs13(d_py);
        a_sx  = abs13(d_sx);
        a_sy  = abs13(d_sy);
        a_lap = abs13(d_lap);

        q_px     = {10'd0, a_px} * {12'd0, DIV3_RECIP};
        q_py     = {10'd0, a_py} * {12'd0, DIV3_RECIP};
        box_prod = {25'd0, sum_all} * {12'd0, BOX_RECIP};

        case (mode)
            KM_BOX:       result = box_prod[BOX_SHIFT +: 8];
            KM_GAUSS:     result = gauss_sum[11:4];
            KM_PREWITT_X: result = q_px[DIV3_SHIFT +: 8];
            KM_PREWITT_Y: result = q_py[DIV3_SHIFT +: 8];
            KM_SOBEL_X:   result = a_sx[9:2];
            KM_SOBEL_Y:   result = a_sy[9:2];
            KM_LAPLACE:   result = a_lap[10:3];
            default:
            begin
                // sharpen: clamp 9*centre - others to 0..255
                if (d_shp[12])
                    result = 8'd0;
                else if (d_shp[11:8] != 4'd0)
                    result = 8'hFF;
                else
                    result = d_shp[7:0];
            end
        endcase
    end

endmodule

[src/window_3x3_kernel_filter.sv]
// 3x3 window kernel filter on a raster-order 8-bit grayscale pixel stream.
// Takes one pixel word per clock while the output is not stalled. It gives
// one filtered word for every interior centre pixel. An incoming pixel in
// column 0 or 1, or in row 0 or 1, completes no full window and produces no
// output word. There are two register stages. An accepted word sits in stage
// 1 while the two line stores are read; each store has one read port and one
// write port. The kernel result is then loaded into the output register.
// One word per clock is sustained while the output is not stalled, set by
// the single registered pass and the separate line store read and write
// ports. A stalled output holds both stages; ready drops once stage 1 is full.
// The line stores are not cleared at reset, and a result only uses entries
// written earlier. Widening a row mid-frame must stay within columns already
// written since reset. kernel_mode, image_width and image_height (index 0, 1, 2
// on the write port) must be written while the block is drained. Width is
// clamped to 3..MAX_WIDTH, height to 3..1024.
module window_3x3_kernel_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    w3kf_pix_in_if.sink                   in_ch,
    w3kf_pix_out_if.source                out_ch,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [w3kf_pkg::CFG_DW-1:0]   cfg_data
);
    import w3kf_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WCW = (XW + 1 > CFG_DW) ? XW + 1 : CFG_DW;
    localparam int XE  = (XW > 10) ? XW : 10;

    // configuration
    kernel_mode_t  kernel_mode_reg;
    logic [10:0]   image_width_reg;
    logic [10:0]   image_height_reg;

    // position of the next incoming pixel
    logic [XW-1:0] col_reg, col_next;
    logic [9:0]    row_reg, row_next;

    // stage 1: pixel plus line store read in flight
    logic          s1_valid_reg;
    pix_t          s1_pix_reg;
    logic [XW-1:0] s1_x_reg;
    logic [9:0]    s1_y_reg;

    // two previous columns of the window: [row][0] = x-2, [row][1] = x-1
    pix_t          win_reg [3][2];

    // output register
    logic          out_valid_reg;
    pix_t          out_pix_reg;
    logic [9:0]    out_cx_reg;
    logic [9:0]    out_cy_reg;

    logic          in_acc, out_free, s1_adv, interior;
    logic [WCW-1:0] w_use, iw_ext, col_inc;
    logic [10:0]   h_use, row_t, row_inc;
    logic          col_wrap;
    logic [XW-1:0] xs;
    logic [9:0]    ys;
    logic [XE-1:0] x_m1;
    pix_t          up_q, mid_q, kern_pix;
    win_t          win;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_acc   = in_ch.valid && in_ch.ready;

    // clamp frame dimensions
    always_comb
    begin
        iw_ext = WCW'(image_width_reg);
        if (iw_ext < WCW'(DIM_MIN))
            w_use = WCW'(DIM_MIN);
        else if (iw_ext > WCW'(MAX_WIDTH))
            w_use = WCW'(MAX_WIDTH);
        else
            w_use = iw_ext;

        if (image_height_reg < DIM_MIN)
            h_use = DIM_MIN;
        else if (image_height_reg > HEIGHT_MAX)
            h_use = HEIGHT_MAX;
        else
            h_use = image_height_reg;
    end

    // Position of this pixel, then of the next. A stored column at or past the
    // width (after a width change) starts a new row; a row at or past the
    // height starts a new frame.
    always_comb
    begin
        col_wrap = WCW'(col_reg) >= w_use;
        xs       = col_wrap ? '0 : col_reg;
        row_t    = col_wrap ? {1'b0, row_reg} + 11'd1 : {1'b0, row_reg};
        ys       = (row_t >= h_use) ? 10'd0 : row_t[9:0];
        col_inc  = WCW'(xs) + WCW'(1);
        row_inc  = {1'b0, ys} + 11'd1;
        if (col_inc >= w_use)
        begin
            col_next = '0;
            row_next = (row_inc >= h_use) ? 10'd0 : row_inc[9:0];
        end
        else
        begin
            col_next = col_inc[XW-1:0];
            row_next = ys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg  <= KM_BOX;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KERNEL_MODE:  kernel_mode_reg  <= kernel_mode_t'(cfg_data[2:0]);
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_ch.ready)
                s1_valid_reg <= in_acc;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg <= in_ch.pixel_in;
            s1_x_reg   <= xs;
            s1_y_reg   <= ys;
        end
    end

    // Line store read issues on accept; the write-back of the same column
    // happens when the word leaves stage 1. Consecutive words never share a
    // column, so the read never sees a pending write.
    w3kf_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (xs),
        .up_q    (up_q),
        .mid_q   (mid_q),
        .wr_en   (s1_adv),
        .wr_addr (s1_x_reg),
        .wr_up   (mid_q),
        .wr_mid  (s1_pix_reg)
    );

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win_reg[r][0];
            win[r][1] = win_reg[r][1];
        end
        win[0][2] = up_q;
        win[1][2] = mid_q;
        win[2][2] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= '0;
                win_reg[r][1] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win[r][1];
                win_reg[r][1] <= win[r][2];
            end
        end
    end

    w3kf_kernel u_kernel (
        .win    (win),
        .mode   (kernel_mode_reg),
        .result (kern_pix)
    );

    assign interior = (s1_x_reg >= XW'(2)) && (s1_y_reg >= 10'd2);
    assign x_m1     = XE'(s1_x_reg) - XE'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg && interior;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && interior)
        begin
            out_pix_reg <= kern_pix;
            out_cx_reg  <= x_m1[9:0];
            out_cy_reg  <= s1_y_reg - 10'd1;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = out_pix_reg;
    assign out_ch.centre_x  = out_cx_reg;
    assign out_ch.centre_y  = out_cy_reg;

endmodule

[src/w3kf_checker.sv]
// Port-level assertions for the window filter, bound to the top level.
module w3kf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_out,
    input logic [9:0] centre_x,
    input logic [9:0] centre_y
);

    // a stalled output word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // a stalled output word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(pixel_out) && $stable(centre_x) && $stable(centre_y))
        else $error("output payload changed while stalled");

    // a fresh output word follows an earlier input accept
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output word without matching input");

    // centre rows start at 1: the top row never has a full window
    a_centre_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> centre_y != 10'd0)
        else $error("output word for a border row");

endmodule

bind window_3x3_kernel_filter w3kf_checker u_w3kf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pixel_out (out_ch.pixel_out),
    .centre_x  (out_ch.centre_x),
    .centre_y  (out_ch.centre_y)
);

[tb/sv/window_3x3_kernel_filter_test.sv]
// Self-checking testbench for the 3x3 window kernel filter: all kernels, size clamps, idling.
module window_3x3_kernel_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import w3kf_pkg::*;

    localparam int         LINE_DEPTH = 1024;   // MAX_WIDTH of the instance below
    localparam int         FILL_WIDTH = 24;     // widest row used past row 1 of a frame
    localparam int         SETTLE     = 8;      // cycles past the last word
    localparam logic [1:0] REG_UNUSED = 2'd3;   // index with no register behind it
    localparam pix_t       PIX_MAX    = 8'hFF;
    localparam pix_t       PIX_MIN    = 8'h00;

    // One filtered word as it should leave the block.
    typedef struct {
        pix_t       value;
        logic [9:0] cx;
        logic [9:0] cy;
    } filtered_word_t;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    w3kf_pix_in_if  in_ch();
    w3kf_pix_out_if out_ch();

    window_3x3_kernel_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Filter shadow: registers, line stores, window columns, position.
    // ------------------------------------------------------------------
    kernel_mode_t   mode_reg   = KM_BOX;
    logic [10:0]    width_reg  = WIDTH_RESET;
    logic [10:0]    height_reg = HEIGHT_RESET;

    pix_t           upper_row  [LINE_DEPTH];
    pix_t           middle_row [LINE_DEPTH];
    pix_t           held_cols  [3][2];          // [row][0 = x-2, 1 = x-1]
    int             col_pos    = 0;             // position of the next pixel
    int             row_pos    = 0;

    filtered_word_t filtered_due[$];            // words still owed by the block

    int             mismatch_count = 0;
    int             sender_idle_pct = 0;        // chance per cycle that no pixel is offered
    int             stall_pct = 0;              // chance per cycle that out ready is low

    initial
    begin
        for (int r = 0; r < 3; r++)
        begin
            held_cols[r][0] = '0;
            held_cols[r][1] = '0;
        end
    end

    function automatic int magnitude(int v);
        return v < 0 ? -v : v;
    endfunction

    // Kernel arithmetic on one neighborhood; all divisions truncate.
    function automatic pix_t kernel_value(win_t win, kernel_mode_t mode);
        int px [3][3];
        int t, b, l, r, all, ctr, others, corners, edges, v;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                px[i][j] = int'(win[i][j]);
        t       = px[0][0] + px[0][1] + px[0][2];
        b       = px[2][0] + px[2][1] + px[2][2];
        l       = px[0][0] + px[1][0] + px[2][0];
        r       = px[0][2] + px[1][2] + px[2][2];
        all     = t + b + px[1][0] + px[1][1] + px[1][2];
        ctr     = px[1][1];
        others  = all - ctr;
        corners = px[0][0] + px[0][2] + px[2][0] + px[2][2];
        edges   = px[0][1] + px[1][0] + px[1][2] + px[2][1];
        case (mode)
            KM_BOX:           v = (all * 11111) / 100000;
            KM_GAUSS:         v = (corners + 2 * edges + 4 * ctr) / 16;
            KM_PREWITT_X:     v = magnitude(r - l) / 3;
            KM_PREWITT_Y:     v = magnitude(b - t) / 3;
            KM_SOBEL_X:       v = magnitude((r + px[1][2]) - (l + px[1][0])) / 4;
            KM_SOBEL_Y:       v = magnitude((b + px[2][1]) - (t + px[0][1])) / 4;
            KM_LAPLACE:       v = magnitude(8 * ctr - others) / 8;
            default:
            begin
                // sharpen: centre weight 9, clamped both ways
                v = 9 * ctr - others;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
        endcase
        return pix_t'(v);
    endfunction

    // Advance the shadow by one accepted pixel and queue the word it causes.
    task automatic predict_pixel(pix_t pix);
        int   w, h, x, y;
        pix_t up, mid;
        win_t win;
        w = int'(width_reg);
        h = int'(height_reg);
        if (w < 3)          w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h < 3)          h = 3;
        if (h > 1024)       h = 1024;

        // A size written mid-frame takes effect here: wrap row, then frame.
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        x = col_pos;
        y = row_pos;

        up             = upper_row[x];
        mid            = middle_row[x];
        upper_row[x]   = mid;
        middle_row[x]  = pix;

        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = held_cols[k][0];
            win[k][1] = held_cols[k][1];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;

        // Only interior centres give a word.
        if (x >= 2 && y >= 2)
            filtered_due.push_back('{kernel_value(win, mode_reg), 10'(x - 1), 10'(y - 1)});

        for (int k = 0; k < 3; k++)
        begin
            held_cols[k][0] = win[k][1];
            held_cols[k][1] = win[k][2];
        end

        col_pos = x + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking: every accepted output word against the oldest owed word.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (mismatch_count < 100)
            $display("%0t ns  mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_words
        filtered_word_t due;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (filtered_due.size() == 0)
                report_mismatch($sformatf("unexpected word %0d at centre (%0d,%0d)",
                                          out_ch.pixel_out, out_ch.centre_x, out_ch.centre_y));
            else
            begin
                due = filtered_due.pop_front();
                if (out_ch.pixel_out !== due.value)
                    report_mismatch($sformatf("pixel_out %0d, expected %0d at centre (%0d,%0d)",
                                              out_ch.pixel_out, due.value, due.cx, due.cy));
                if (out_ch.centre_x !== due.cx)
                    report_mismatch($sformatf("centre_x %0d, expected %0d",
                                              out_ch.centre_x, due.cx));
                if (out_ch.centre_y !== due.cy)
                    report_mismatch($sformatf("centre_y %0d, expected %0d",
                                              out_ch.centre_y, due.cy));
            end
        end
    end

    // Output back-pressure, redrawn every cycle.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic set_idling(int sender_pct, int receiver_pct);
        sender_idle_pct = sender_pct;
        stall_pct       = receiver_pct;
    endtask

    // Offer one pixel word, hold it until taken, then update the shadow.
    task automatic send_pixel(pix_t pix);
        int gap;
        gap = 0;
        while (gap < 64 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.pixel_in <= pix;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_pixel(pix);
        @(negedge clk);
    endtask

    // Bias toward black and white so the clamps and extremes get hit often.
    function automatic pix_t random_pixel();
        case ($urandom_range(7))
            0:       return PIX_MIN;
            1:       return PIX_MAX;
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // Drop valid, wait for every owed word, then let border pixels drain.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // One register write; only called while the block is drained.
    task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_KERNEL_MODE:  mode_reg   = kernel_mode_t'(data[2:0]);
            REG_IMAGE_WIDTH:  width_reg  = data;
            REG_IMAGE_HEIGHT: height_reg = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One full frame at the widest row used later. Fills both line stores in
    // every column that a later row past row 1 can reach, so nothing later
    // reads a column that was never written.
    task automatic test_fill_lines();
        set_idling(0, 0);
        write_reg(REG_KERNEL_MODE, 11'(KM_SOBEL_X));
        write_reg(REG_IMAGE_WIDTH, 11'(FILL_WIDTH));
        write_reg(REG_IMAGE_HEIGHT, 11'd3);
        send_pixels(3 * FILL_WIDTH);
        wait_idle();
    endtask

    // Width below range clamps to 3, height above range to 1024: rows run on
    // with no early wrap. Then height below range clamps to 3 and frames wrap.
    task automatic test_size_clamps();
        set_idling(0, 0);
        write_reg(REG_KERNEL_MODE, 11'(KM_LAPLACE_SHARP));
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
        send_pixels(30);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 11'd0);        // row past the height: new frame
        send_pixels(21);
        wait_idle();
    endtask

    // Each kernel over rows chosen for its extremes: dark centre in a white
    // field, white centre in a black field, full left/right contrast; the
    // block edges give top/bottom contrast.
    task automatic test_every_kernel();
        pix_t rows [9][3];
        rows = '{'{PIX_MAX, PIX_MAX, PIX_MAX},
                 '{PIX_MAX, PIX_MIN, PIX_MAX},
                 '{PIX_MAX, PIX_MAX, PIX_MAX},
                 '{PIX_MIN, PIX_MIN, PIX_MIN},
                 '{PIX_MIN, PIX_MAX, PIX_MIN},
                 '{PIX_MIN, PIX_MIN, PIX_MIN},
                 '{PIX_MAX, PIX_MIN, PIX_MIN},
                 '{PIX_MAX, PIX_MIN, PIX_MIN},
                 '{PIX_MAX, PIX_MIN, PIX_MIN}};
        set_idling(25, 25);
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd1024);
        for (int m = 0; m < 8; m++)
        begin
            write_reg(REG_KERNEL_MODE, 11'(m));
            for (int r = 0; r < 9; r++)
                for (int c = 0; c < 3; c++)
                    send_pixel(rows[r][c]);
            wait_idle();
        end
    endtask

    // Sizes and mode rewritten part way through rows and frames.
    task automatic test_midframe_changes();
        set_idling(75, 0);
        write_reg(REG_KERNEL_MODE, 11'(KM_GAUSS));
        write_reg(REG_IMAGE_WIDTH, 11'h7FF);       // clamps to the line store depth
        write_reg(REG_IMAGE_HEIGHT, 11'd6);        // current row is past it: new frame
        send_pixels(10);                           // stays in row 0
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 11'd4);         // column past the width: next row
        send_pixels(14);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 11'd9);         // row grows mid-way
        send_pixels(16);                           // ends the frame, wraps to the top
        send_pixels(32);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 11'd3);        // row past the height: new frame
        write_reg(REG_UNUSED, 11'h7FF);            // must leave every register alone
        send_pixels(20);
        wait_idle();
        write_reg(REG_KERNEL_MODE, {8'hA5, KM_PREWITT_Y});  // upper bits ignored
        send_pixels(16);
        wait_idle();
    endtask

    // Random sizes, modes and pixels under one idling pattern.
    task automatic random_phase(int sender_pct, int receiver_pct, int items);
        int sent, count;
        set_idling(sender_pct, receiver_pct);
        sent = 0;
        while (sent < items)
        begin
            write_reg(REG_KERNEL_MODE, {8'($urandom_range(255)), 3'($urandom_range(7))});
            if ($urandom_range(1))
            begin
                case ($urandom_range(9))
                    0:       write_reg(REG_IMAGE_WIDTH, 11'($urandom_range(2)));
                    1:       write_reg(REG_IMAGE_WIDTH, 11'($urandom_range(FILL_WIDTH, 13)));
                    default: write_reg(REG_IMAGE_WIDTH, 11'($urandom_range(12, 3)));
                endcase
            end
            if ($urandom_range(1))
            begin
                if ($urandom_range(7) == 0)
                    write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(2)));
                else
                    write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(8, 3)));
            end
            count = $urandom_range(60, 10);
            send_pixels(count);
            sent += count;
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 36);
        random_phase(75, 0, 36);
        random_phase(0, 75, 36);
        random_phase(25, 25, 36);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.pixel_in = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_fill_lines();
        test_size_clamps();
        test_every_kernel();
        test_midframe_changes();
        test_random_traffic();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
